FILE: rtl/pdsp_pkg.sv
// ----------------------------------------------------------------------------
// pdsp_pkg
// Shared types and constants for the PLL divider serial programmer.
// ----------------------------------------------------------------------------
package pdsp_pkg;

  // divider field sizes
  localparam int REF_DIVIDER_BITS = 16;
  localparam int N_DIVIDER_BITS   = 24;

  // field widths
  localparam int FREQ_W = 26;
  localparam int STEP_W = 6;
  localparam int MOD_W  = 3;
  localparam int WORD_W = 16;
  localparam int CFG_W  = 26;
  localparam int SB_W   = 16;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // divider datapath: numerator is freq + offset, so one bit wider than a frequency
  localparam int NUM_W      = FREQ_W + 1;
  localparam int DEN_W      = 16;
  localparam int ITER_CNT_W = $clog2(NUM_W);
  localparam int KHZ_FACTOR = 1000;

  localparam int MAX_FRAME_BITS =
    (N_DIVIDER_BITS > REF_DIVIDER_BITS) ? N_DIVIDER_BITS : REF_DIVIDER_BITS;
  localparam int BIT_CNT_W = $clog2(MAX_FRAME_BITS);

  localparam logic [NUM_W-1:0] REF_MAX =
    NUM_W'((64'd1 << REF_DIVIDER_BITS) - 64'd1);
  localparam logic [NUM_W-1:0] N_MAX =
    NUM_W'((64'd1 << N_DIVIDER_BITS) - 64'd1);

  // register indexes
  localparam logic [IDX_W-1:0] REG_REF_CLOCK = 2'd0;
  localparam logic [IDX_W-1:0] REG_IF_OFFSET = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIDEBAND  = 2'd2;

  localparam logic [CFG_W-1:0] REF_CLOCK_RESET = 26'd10240000;
  localparam logic [CFG_W-1:0] IF_OFFSET_RESET = 26'd10695000;
  localparam logic [SB_W-1:0]  SIDEBAND_RESET  = 16'd5000;

  // modulation codes
  localparam logic [MOD_W-1:0] MOD_USB = 3'd0;
  localparam logic [MOD_W-1:0] MOD_LSB = 3'd1;
  localparam logic [MOD_W-1:0] MOD_FM  = 3'd2;
  localparam logic [MOD_W-1:0] MOD_AM  = 3'd3;

  // driver latch
  localparam logic [WORD_W-1:0] LATCH_RESET = 16'h8202;
  localparam logic [WORD_W-1:0] SEL_FM      = 16'h0002;
  localparam logic [WORD_W-1:0] SEL_AM      = 16'h0004;
  localparam logic [WORD_W-1:0] SEL_LSB     = 16'h0008;
  localparam logic [WORD_W-1:0] SEL_USB     = 16'h0010;
  localparam logic [WORD_W-1:0] MODE_MASK   = SEL_FM | SEL_AM | SEL_LSB | SEL_USB;

  // record kinds
  localparam logic [KIND_W-1:0] KIND_DRIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BIT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] driver_word;
    logic [NUM_W-1:0]  num_ref;
    logic [NUM_W-1:0]  num_n;
    logic [DEN_W-1:0]  den;
  } pdsp_job_t;

  typedef struct packed {
    logic [WORD_W-1:0]           driver_word;
    logic [REF_DIVIDER_BITS-1:0] ref_div;
    logic [N_DIVIDER_BITS-1:0]   n_div;
  } pdsp_result_t;

endpackage

FILE: rtl/pdsp_front.sv
// ----------------------------------------------------------------------------
// pdsp_front
// Config registers, request decode, driver latch update and a two-entry
// job queue toward the divider.
// ----------------------------------------------------------------------------
module pdsp_front
  import pdsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  job_valid,
  input  logic                  job_ready,
  output pdsp_job_t             job
);

  logic [CFG_W-1:0]  ref_clock;
  logic [CFG_W-1:0]  if_offset;
  logic [SB_W-1:0]   sideband;
  logic [WORD_W-1:0] latch;
  logic [WORD_W-1:0] latch_next;

  logic [FREQ_W-1:0] freq;
  logic [STEP_W-1:0] step;
  logic [MOD_W-1:0]  modulation;
  logic [FREQ_W-1:0] freq_adj;
  logic [DEN_W-1:0]  den;

  pdsp_job_t q_mem [2];
  pdsp_job_t q_in;
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] q_count;
  logic      push;
  logic      pop;

  assign freq       = s_tdata[FREQ_W-1:0];
  assign step       = s_tdata[FREQ_W+STEP_W-1:FREQ_W];
  assign modulation = s_tdata[FREQ_W+STEP_W+MOD_W-1:FREQ_W+STEP_W];

  always_comb begin
    latch_next = latch;
    freq_adj   = freq;
    case (modulation)
      MOD_USB: latch_next = (latch & ~MODE_MASK) | SEL_USB;
      MOD_LSB: begin
        latch_next = (latch & ~MODE_MASK) | SEL_LSB;
        freq_adj   = (freq >= FREQ_W'(sideband)) ? freq - FREQ_W'(sideband) : '0;
      end
      MOD_FM:  latch_next = (latch & ~MODE_MASK) | SEL_FM;
      MOD_AM:  latch_next = (latch & ~MODE_MASK) | SEL_AM;
      default: ;
    endcase
  end

  assign den = DEN_W'(step) * DEN_W'(KHZ_FACTOR);

  assign q_in.driver_word = latch_next;
  assign q_in.num_ref     = NUM_W'(ref_clock);
  assign q_in.num_n       = NUM_W'(freq_adj) + NUM_W'(if_offset);
  assign q_in.den         = den;

  assign s_tready  = (q_count != 2'd2);
  assign job_valid = (q_count != 2'd0);
  assign job       = q_mem[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= REF_CLOCK_RESET;
      if_offset <= IF_OFFSET_RESET;
      sideband  <= SIDEBAND_RESET;
      latch     <= LATCH_RESET;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      q_count   <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REF_CLOCK: ref_clock <= cfg_data;
          REG_IF_OFFSET: if_offset <= cfg_data;
          REG_SIDEBAND:  sideband  <= cfg_data[SB_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        latch  <= latch_next;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !push) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= q_in;
    end
  end

endmodule

FILE: rtl/pdsp_div.sv
// ----------------------------------------------------------------------------
// pdsp_div
// Shared restoring divider, one quotient bit per cycle. Works out the
// reference and N dividers of a job in turn and saturates each to its field.
// ----------------------------------------------------------------------------
module pdsp_div
  import pdsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_ready,
  input  pdsp_job_t    job,
  output logic         res_valid,
  input  logic         res_ready,
  output pdsp_result_t res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN_REF,
    S_RUN_N,
    S_DONE
  } state_t;

  state_t state;

  logic [NUM_W-1:0]      acc;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic [NUM_W-1:0]      num_n;
  logic [ITER_CNT_W-1:0] cnt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] acc_next;

  // zero divisor: every compare passes and the quotient comes out all ones
  assign rem_sh   = {rem, acc[NUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, den});
  assign diff     = rem_sh - {1'b0, den};
  assign rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign acc_next = {acc[NUM_W-2:0], ge};

  assign job_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            acc             <= job.num_ref;
            num_n           <= job.num_n;
            den             <= job.den;
            res.driver_word <= job.driver_word;
            rem             <= '0;
            cnt             <= ITER_CNT_W'(NUM_W - 1);
            state           <= S_RUN_REF;
          end
        end
        S_RUN_REF: begin
          acc <= acc_next;
          rem <= rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            res.ref_div <= (acc_next > REF_MAX) ? '1 : REF_DIVIDER_BITS'(acc_next);
            acc         <= num_n;
            rem         <= '0;
            cnt         <= ITER_CNT_W'(NUM_W - 1);
            state       <= S_RUN_N;
          end
        end
        S_RUN_N: begin
          acc <= acc_next;
          rem <= rem_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            res.n_div <= (acc_next > N_MAX) ? '1 : N_DIVIDER_BITS'(acc_next);
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pdsp_emit.sv
// ----------------------------------------------------------------------------
// pdsp_emit
// Record sequencer: driver word, then the reference and N frames, one
// record per beat through a registered output stage.
// ----------------------------------------------------------------------------
module pdsp_emit
  import pdsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  pdsp_result_t           res,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]      m_tuser,
  output logic                   m_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRV,
    S_START,
    S_BITS,
    S_STOP,
    S_END
  } state_t;

  state_t state;

  logic [WORD_W-1:0]           word;
  logic [REF_DIVIDER_BITS-1:0] rsh;
  logic [N_DIVIDER_BITS-1:0]   nsh;
  logic                        frame;   // 0 reference frame, 1 N frame
  logic [BIT_CNT_W-1:0]        cnt;
  logic                        adv;
  logic                        load;

  logic [WORD_W-1:0] out_word;
  logic              out_bit;

  assign adv       = !m_tvalid || m_tready;
  // a new beat goes into the output register in every emitting state
  assign load      = adv && (state inside {S_DRV, S_START, S_BITS, S_STOP, S_END});
  assign res_ready = (state == S_IDLE);
  assign m_tdata   = {(OUT_TDATA_W - WORD_W - 1)'(0), out_bit, out_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (res_valid) begin
            word  <= res.driver_word;
            rsh   <= res.ref_div;
            nsh   <= res.n_div;
            state <= S_DRV;
          end
        end
        S_DRV: begin
          if (adv) begin
            m_tuser  <= KIND_DRIVER;
            out_word <= word;
            out_bit  <= 1'b0;
            m_tlast  <= 1'b0;
            frame    <= 1'b0;
            state    <= S_START;
          end
        end
        S_START: begin
          if (adv) begin
            m_tuser  <= KIND_START;
            out_word <= '0;
            out_bit  <= 1'b0;
            m_tlast  <= 1'b0;
            cnt      <= frame ? BIT_CNT_W'(N_DIVIDER_BITS - 1)
                              : BIT_CNT_W'(REF_DIVIDER_BITS - 1);
            state    <= S_BITS;
          end
        end
        S_BITS: begin
          if (adv) begin
            m_tuser  <= KIND_BIT;
            out_word <= '0;
            out_bit  <= frame ? nsh[N_DIVIDER_BITS-1] : rsh[REF_DIVIDER_BITS-1];
            m_tlast  <= 1'b0;
            if (frame) begin
              nsh <= {nsh[N_DIVIDER_BITS-2:0], 1'b0};
            end else begin
              rsh <= {rsh[REF_DIVIDER_BITS-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
            if (cnt == '0) begin
              state <= S_STOP;
            end
          end
        end
        S_STOP: begin
          if (adv) begin
            // stop bit: 1 after the reference divider, 0 after the N divider
            m_tuser  <= KIND_BIT;
            out_word <= '0;
            out_bit  <= ~frame;
            m_tlast  <= 1'b0;
            state    <= S_END;
          end
        end
        S_END: begin
          if (adv) begin
            m_tuser  <= KIND_END;
            out_word <= '0;
            out_bit  <= 1'b0;
            m_tlast  <= frame;
            frame    <= 1'b1;
            state    <= frame ? S_IDLE : S_START;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pll_divider_serial_programmer_top.sv
// ----------------------------------------------------------------------------
// pll_divider_serial_programmer_top
// Tuning requests in, driver word and two three-wire divider frames out.
//
//   port group  dir  payload
//   s_*         in   s_tdata: frequency_hz[25:0], step_khz[31:26], modulation[34:32]
//   m_*         out  m_tdata: driver_word[15:0], bit_value[16]; m_tuser: record_kind;
//                    m_tlast: last
//   cfg_*       in   cfg_index selects register, cfg_data carries the value
//
// A request yields 47 output beats. The shared bit-serial divider works out
// the two quotients of a request one after the other; emission of one request
// overlaps division of the next. A two-entry queue sits between decode and
// divider. Synchronous reset restores the config registers and the driver
// latch. Output stalls back up through the emitter, divider and queue to
// s_tready.
// ----------------------------------------------------------------------------
module pll_divider_serial_programmer_top
  import pdsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // frequency_hz, step_khz, modulation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // driver_word, bit_value
  output logic [KIND_W-1:0]      m_tuser,   // record_kind
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  pdsp_job_t    job;
  logic         job_valid;
  logic         job_ready;
  pdsp_result_t res;
  logic         res_valid;
  logic         res_ready;

  pdsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  pdsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pdsp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PLL divider serial programmer. Tuning requests
// are streamed in with random gaps while the result side stalls at random.
// A behavioral model of the driver latch and both divider frames predicts
// every output beat, and each beat is checked field by field in order.
// Register writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module tb;
  import pdsp_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 150;
  localparam int PHASE1_AT = 115;
  localparam int PHASE2_AT = 230;

  typedef enum logic [1:0] {OP_REQUEST, OP_CONFIG, OP_DRAIN} op_e;

  typedef struct {
    op_e               op;
    logic [FREQ_W-1:0] freq_hz;
    logic [STEP_W-1:0] step_khz;
    logic [MOD_W-1:0]  modulation;
    logic [IDX_W-1:0]  reg_index;
    logic [CFG_W-1:0]  reg_value;
  } pending_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] driver_word;
    logic              bit_val;
    logic              last;
  } record_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pll_divider_serial_programmer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pending_t pending_ops[$];
  record_t  records_due[$];
  int fail_count = 0;
  logic [1:0] idle_phase = 2'd0;

  // shadow of the block's programmable state
  logic [CFG_W-1:0]  ref_clock_hz = REF_CLOCK_RESET;
  logic [CFG_W-1:0]  if_offset_hz = IF_OFFSET_RESET;
  logic [SB_W-1:0]   sideband_hz  = SIDEBAND_RESET;
  logic [WORD_W-1:0] latch_word   = LATCH_RESET;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  task automatic push_record(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                             input logic b);
    record_t r;
    r.kind = kind;
    r.driver_word = word;
    r.bit_val = b;
    r.last = 1'b0;
    records_due.push_back(r);
  endtask

  task automatic push_frame(input longint unsigned value, input int nbits, input logic stop);
    push_record(KIND_START, '0, 1'b0);
    for (int i = nbits - 1; i >= 0; i--)
      push_record(KIND_BIT, '0, value[i]);
    push_record(KIND_BIT, '0, stop);
    push_record(KIND_END, '0, 1'b0);
  endtask

  function automatic longint unsigned quotient_sat(longint unsigned num, longint unsigned den,
                                                   int nbits);
    longint unsigned lim;
    lim = (64'd1 << nbits) - 64'd1;
    if (den == 0)
      return lim;
    return (num / den > lim) ? lim : num / den;
  endfunction

  task automatic predict_request(input pending_t req);
    longint unsigned tuned_hz;
    longint unsigned den;
    logic [WORD_W-1:0] sel;
    tuned_hz = req.freq_hz;
    sel = '0;
    case (req.modulation)
      MOD_FM: sel = SEL_FM;
      MOD_AM: sel = SEL_AM;
      MOD_USB: sel = SEL_USB;
      MOD_LSB: begin
        sel = SEL_LSB;
        tuned_hz = (req.freq_hz >= sideband_hz) ? req.freq_hz - sideband_hz : 0;
      end
      default: ;
    endcase
    if (req.modulation <= MOD_AM)
      latch_word = (latch_word & ~MODE_MASK) | sel;
    push_record(KIND_DRIVER, latch_word, 1'b0);
    den = longint'(req.step_khz) * KHZ_FACTOR;
    push_frame(quotient_sat(ref_clock_hz, den, REF_DIVIDER_BITS), REF_DIVIDER_BITS, 1'b1);
    push_frame(quotient_sat(tuned_hz + if_offset_hz, den, N_DIVIDER_BITS), N_DIVIDER_BITS,
               1'b0);
    records_due[records_due.size() - 1].last = 1'b1;
  endtask

  task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    case (idx)
      REG_REF_CLOCK: ref_clock_hz = value;
      REG_IF_OFFSET: if_offset_hz = value;
      REG_SIDEBAND:  sideband_hz = value[SB_W-1:0];
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_requests
    logic nv;
    logic nwe;
    int send_idle;
    pending_t in_flight;
    int reqs_sent;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nv = s_tvalid;
      nwe = 1'b0;
      if (s_tvalid && s_tready) begin
        predict_request(in_flight);
        reqs_sent++;
        nv = 1'b0;
      end
      send_idle = (idle_phase == 2'd0) ? 30 : (idle_phase == 2'd1) ? 59 : 0;
      if (!nv && pending_ops.size() > 0) begin
        case (pending_ops[0].op)
          OP_REQUEST: if ($urandom_range(99) >= send_idle) begin
            in_flight = pending_ops.pop_front();
            s_tdata <= IN_TDATA_W'({in_flight.modulation, in_flight.step_khz,
                                    in_flight.freq_hz});
            nv = 1'b1;
          end
          OP_DRAIN: if (records_due.size() == 0) begin
            void'(pending_ops.pop_front());
          end
          OP_CONFIG: begin
            cfg_index <= pending_ops[0].reg_index;
            cfg_data <= pending_ops[0].reg_value;
            apply_register(pending_ops[0].reg_index, pending_ops[0].reg_value);
            nwe = 1'b1;
            void'(pending_ops.pop_front());
          end
          default: ;
        endcase
      end
      s_tvalid <= nv;
      cfg_we <= nwe;
      idle_phase <= (reqs_sent < PHASE1_AT) ? 2'd0 : (reqs_sent < PHASE2_AT) ? 2'd1 : 2'd2;
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin : check_records
    record_t want;
    int recv_idle;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (records_due.size() == 0) begin
          $error("unexpected beat: kind %0d word %h", m_tuser, m_tdata[WORD_W-1:0]);
          fail_count++;
        end else begin
          want = records_due.pop_front();
          if (m_tuser !== want.kind) begin
            $error("record_kind expected %0d got %0d", want.kind, m_tuser);
            fail_count++;
          end
          if (m_tdata[WORD_W-1:0] !== want.driver_word) begin
            $error("driver_word expected %h got %h", want.driver_word, m_tdata[WORD_W-1:0]);
            fail_count++;
          end
          if (m_tdata[WORD_W] !== want.bit_val) begin
            $error("bit_value expected %0d got %0d", want.bit_val, m_tdata[WORD_W]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last expected %0d got %0d", want.last, m_tlast);
            fail_count++;
          end
        end
      end
      recv_idle = (idle_phase == 2'd0) ? 59 : (idle_phase == 2'd1) ? 30 : 0;
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ----------------------------------------------------------------- watchdog
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_request(input logic [FREQ_W-1:0] f, input logic [STEP_W-1:0] s,
                             input logic [MOD_W-1:0] m);
    pending_t p;
    p = '{op: OP_REQUEST, freq_hz: f, step_khz: s, modulation: m,
          reg_index: '0, reg_value: '0};
    pending_ops.push_back(p);
  endtask

  task automatic add_config(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    pending_t p;
    p = '{op: OP_CONFIG, freq_hz: '0, step_khz: '0, modulation: '0,
          reg_index: idx, reg_value: value};
    pending_ops.push_back(p);
  endtask

  task automatic add_drain();
    pending_t p;
    p = '{op: OP_DRAIN, freq_hz: '0, step_khz: '0, modulation: '0,
          reg_index: '0, reg_value: '0};
    pending_ops.push_back(p);
  endtask

  function automatic logic [CFG_W-1:0] random_setting();
    case ($urandom_range(3))
      0: return CFG_W'($urandom);
      1: return CFG_W'($urandom_range(1000000, 50000000));
      2: return {CFG_W{1'b1}};
      default: return CFG_W'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic logic [FREQ_W-1:0] random_freq();
    case ($urandom_range(9))
      0: return '0;
      1: return FREQ_MAX;
      2: return FREQ_W'($urandom_range(0, 70000));   // around the sideband shift
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  initial begin
    // directed: every modulation code at reset settings
    add_request(26'd7100000, 6'd5, MOD_USB);
    add_request(26'd7100000, 6'd1, MOD_LSB);
    add_request(26'd29000000, 6'd10, MOD_FM);
    add_request(26'd1000000, 6'd9, MOD_AM);
    add_request(26'd14000000, 6'd3, 3'd4);
    add_request(26'd21000000, 6'd25, 3'd5);
    add_request(26'd3500000, 6'd12, 3'd6);
    add_request(26'd50000000, 6'd50, 3'd7);
    add_request(26'd100, 6'd1, MOD_LSB);          // sideband underflow
    add_request('0, 6'd63, MOD_FM);
    add_request(FREQ_MAX, 6'd1, MOD_USB);
    add_request(26'd14200000, 6'd0, MOD_AM);      // zero step saturates both
    // top of every register, plus a write to an unused index
    add_drain();
    add_config(REG_REF_CLOCK, {CFG_W{1'b1}});
    add_config(REG_IF_OFFSET, {CFG_W{1'b1}});
    add_config(REG_SIDEBAND, {CFG_W{1'b1}});
    add_config(REG_UNUSED, 26'h2AAAAAA);
    add_request(FREQ_MAX, 6'd1, MOD_LSB);         // reference quotient too wide
    add_request(26'd60000, 6'd1, MOD_LSB);
    add_request(FREQ_MAX, 6'd63, 3'd4);
    add_request('0, 6'd0, MOD_FM);
    // bottom of the offset and sideband registers, reference clock at 1
    add_drain();
    add_config(REG_REF_CLOCK, 26'd1);
    add_config(REG_IF_OFFSET, '0);
    add_config(REG_SIDEBAND, '0);
    add_request('0, 6'd1, MOD_LSB);
    add_request(FREQ_MAX, 6'd63, MOD_USB);
    add_request(26'd5, 6'd0, MOD_LSB);
    // random segments, each behind a drain and a few register writes
    for (int seg = 0; seg < 8; seg++) begin
      add_drain();
      for (int w = $urandom_range(1, 3); w > 0; w--)
        add_config(IDX_W'($urandom_range(3)), random_setting());
      for (int n = 0; n < 40; n++)
        add_request(random_freq(), ($urandom_range(19) == 0) ? 6'd0 :
                    STEP_W'($urandom_range(1, 63)), MOD_W'($urandom_range(7)));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_ops.size() != 0 || s_tvalid || records_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
